// ===== design/code_block_segment_crc24b_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the code block segmentation unit
// Immediate-consequence and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef CODE_BLOCK_SEGMENT_CRC24B_UNIT_MACROS_SVH
`define CODE_BLOCK_SEGMENT_CRC24B_UNIT_MACROS_SVH

// check that cons holds in the cycle where ante holds
`define CBS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbs check failed");

// check that cons holds in the cycle after ante holds
`define CBS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbs check failed");

`endif

// ===== design/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg
// Types, constants and helper functions of the code block segmentation unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cbs_pkg;

   localparam int MaxSegment   = 6144;
   localparam int MaxBlockBits = 131071;
   localparam int CrcWidth     = 24;
   localparam int NumSizes     = 188;
   localparam int SegPayload   = MaxSegment - CrcWidth;

   localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
   localparam logic [1:0] REG_CRC_POLY     = 2'd1;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_FILL = 2'd1,
      KIND_CRC  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEG,
      ST_FILL,
      ST_WAIT,
      ST_DATA,
      ST_CRC
   } state_type;

   typedef enum logic [1:0] {
      SEG_IDLE,
      SEG_COUNT,
      SEG_SEARCH,
      SEG_FINISH
   } seg_state_type;

   typedef struct packed {
      logic [4:0]  num_blocks;
      logic [12:0] size_plus;
      logic [12:0] size_minus;
      logic [4:0]  count_minus;
      logic [5:0]  filler_count;
   } seg_type;

   // interleaver block size for table entry i
   function automatic logic [12:0] table_size(input logic [7:0] i);
      int v;
      v = int'(i);
      if (v < 60)       table_size = 13'(40 + 8 * v);
      else if (v < 92)  table_size = 13'(512 + 16 * (v - 59));
      else if (v < 124) table_size = 13'(1024 + 32 * (v - 91));
      else              table_size = 13'(2048 + 64 * (v - 123));
   endfunction

   // log2 of the size step between entry i-1 and entry i
   function automatic logic [2:0] step_shift(input logic [7:0] i);
      if (i <= 8'd59)       step_shift = 3'd3;
      else if (i <= 8'd91)  step_shift = 3'd4;
      else if (i <= 8'd123) step_shift = 3'd5;
      else                  step_shift = 3'd6;
   endfunction

   // one step of the serial CRC register
   function automatic logic [CrcWidth-1:0] crc_shift(input logic [CrcWidth-1:0] crc,
                                                     input logic bit_in,
                                                     input logic [CrcWidth-1:0] poly);
      logic fb;
      fb = crc[CrcWidth-1] ^ bit_in;
      crc_shift = {crc[CrcWidth-2:0], 1'b0} ^ (fb ? poly : '0);
   endfunction

endpackage
`default_nettype wire

// ===== design/cbs_seg_calc.sv =====
// ----------------------------------------------------------------------------
// cbs_seg_calc
// Derives C, K+, K-, C- and F for one transport block length by repeated
// subtraction and a one-entry-per-cycle search through the block-size table.
// ----------------------------------------------------------------------------
`default_nettype none
module cbs_seg_calc
   import cbs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [16:0] block_length,
   output logic             done,
   output seg_type          seg
);

   seg_state_type state_ff, state_in;
   logic [16:0] b_ff, b_in;
   logic [16:0] rem_ff, rem_in;
   logic [4:0]  c_ff, c_in;
   logic [17:0] bp_ff, bp_in;
   logic [7:0]  idx_ff, idx_in;
   logic        done_ff, done_in;
   seg_type     seg_ff, seg_in;

   logic [12:0] kp, km;
   logic [17:0] prod, diff;
   logic        fits;
   logic [2:0]  sh;
   logic [12:0] cm_raw;
   logic [4:0]  cm;
   logic [17:0] f_full;
   logic [16:0] b_start;

   // shared multiplier: blocks times candidate size
   assign kp   = table_size(idx_ff);
   assign prod = 18'(c_ff) * 18'(kp);
   assign fits = prod >= bp_ff;
   assign diff = prod - bp_ff;
   assign sh   = step_shift(idx_ff);
   assign km   = (idx_ff != 8'd0) ? table_size(idx_ff - 8'd1) : kp;
   assign cm_raw = 13'(diff >> sh);
   assign b_start = (block_length == 17'd0) ? 17'd1 : block_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      b_ff   <= b_in;
      rem_ff <= rem_in;
      c_ff   <= c_in;
      bp_ff  <= bp_in;
      idx_ff <= idx_in;
      seg_ff <= seg_in;
   end

   always_comb begin
      state_in = state_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      c_in     = c_ff;
      bp_in    = bp_ff;
      idx_in   = idx_ff;
      seg_in   = seg_ff;
      done_in  = 1'b0;
      cm       = '0;
      f_full   = '0;
      case (state_ff)
         SEG_IDLE: begin
            if (start) begin
               b_in   = b_start;
               rem_in = b_start;
               c_in   = 5'd1;
               idx_in = '0;
               bp_in  = 18'(b_start);
               if (int'(b_start) > MaxSegment) state_in = SEG_COUNT;
               else                            state_in = SEG_SEARCH;
            end
         end
         SEG_COUNT: begin
            // count code blocks as ceil(B / payload)
            if (int'(rem_ff) > SegPayload) begin
               rem_in = rem_ff - 17'(SegPayload);
               c_in   = c_ff + 5'd1;
            end else begin
               bp_in    = 18'(b_ff) + 18'(c_ff) * 18'(CrcWidth);
               state_in = SEG_SEARCH;
            end
         end
         SEG_SEARCH: begin
            // advance until C times the size covers B'
            if (fits || int'(idx_ff) == NumSizes - 1) state_in = SEG_FINISH;
            else                                       idx_in = idx_ff + 8'd1;
         end
         SEG_FINISH: begin
            if (c_ff > 5'd1 && idx_ff != 8'd0 && fits) begin
               cm = (cm_raw > 13'(c_ff)) ? c_ff : 5'(cm_raw);
            end
            if (fits) f_full = diff - (18'(cm) << sh);
            seg_in.num_blocks   = c_ff;
            seg_in.size_plus    = kp;
            seg_in.size_minus   = (c_ff > 5'd1) ? km : 13'd0;
            seg_in.count_minus  = cm;
            seg_in.filler_count = (f_full > 18'd63) ? 6'd63 : 6'(f_full);
            done_in  = 1'b1;
            state_in = SEG_IDLE;
         end
         default: begin
            state_in = SEG_IDLE;
         end
      endcase
   end

   assign done = done_ff;
   assign seg  = seg_ff;

endmodule
`default_nettype wire

// ===== design/code_block_segment_crc24b_unit.sv =====
// A transport block's first bit waits for segmentation (count, table search,
// finish) and F filler bits before its data; each later bit is accepted, then
// emitted. For C > 1, a block's last data bit is followed by its 24 CRC bits.
// Results leave through a single output register, one per cycle for filler
// and CRC bits while rsp_stall is low. Reset (synchronous, active high) idles
// the sequencer and restores block_length 40 and crc_poly 0x800063.
// ----------------------------------------------------------------------------
// code_block_segment_crc24b_unit
// Splits a serial transport block into turbo code blocks with filler and
// CRC24B attachment for C > 1, at most one output bit per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "code_block_segment_crc24b_unit_macros.svh"
module code_block_segment_crc24b_unit
   import cbs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_data_bit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_out_bit,
   output logic [1:0]       rsp_bit_kind,
   output logic [4:0]       rsp_block_index,
   output logic             rsp_block_end,
   output logic             rsp_run_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   state_type   state_ff, state_in;
   logic [16:0] blen_ff, blen_in;
   logic [23:0] poly_ff, poly_in;
   logic        bit_ff, bit_in;
   logic [4:0]  cur_ff, cur_in;
   logic [12:0] bits_ff, bits_in;
   logic [23:0] crc_ff, crc_in;
   logic [4:0]  cidx_ff, cidx_in;
   logic        rv_ff, rv_in;
   logic        ob_ff, ob_in;
   kind_type    ok_ff, ok_in;
   logic [4:0]  oi_ff, oi_in;
   logic        oe_ff, oe_in;
   logic        ol_ff, ol_in;

   logic        seg_start, seg_done;
   seg_type     seg;
   logic        out_free, multi, last;
   logic [12:0] ksize, dlen, bits_next;
   logic [23:0] crc_next;
   logic [5:0]  cur_next;

   cbs_seg_calc u_seg (
      .clock        (clock),
      .reset        (reset),
      .start        (seg_start),
      .block_length (blen_ff),
      .done         (seg_done),
      .seg          (seg)
   );

   // configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      blen_in = blen_ff;
      poly_in = poly_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_BLOCK_LENGTH: blen_in = csr_data[16:0];
            REG_CRC_POLY:     poly_in = csr_data;
            default:          ;
         endcase
      end
   end

   // per-block data length
   assign multi     = seg.num_blocks > 5'd1;
   assign ksize     = (cur_ff < seg.count_minus) ? seg.size_minus : seg.size_plus;
   assign dlen      = multi ? ((ksize > 13'(CrcWidth)) ? ksize - 13'(CrcWidth) : 13'd0)
                            : ksize;
   assign bits_next = bits_ff + 13'd1;
   assign crc_next  = crc_shift(crc_ff, bit_ff, poly_ff);
   assign last      = bits_next >= dlen;
   assign cur_next  = 6'(cur_ff) + 6'd1;
   assign out_free  = !rv_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         blen_ff  <= 17'd40;
         poly_ff  <= 24'd8388707;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         blen_ff  <= blen_in;
         poly_ff  <= poly_in;
      end
      bit_ff  <= bit_in;
      cur_ff  <= cur_in;
      bits_ff <= bits_in;
      crc_ff  <= crc_in;
      cidx_ff <= cidx_in;
      ob_ff   <= ob_in;
      ok_ff   <= ok_in;
      oi_ff   <= oi_in;
      oe_ff   <= oe_in;
      ol_ff   <= ol_in;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      bit_in    = bit_ff;
      cur_in    = cur_ff;
      bits_in   = bits_ff;
      crc_in    = crc_ff;
      cidx_in   = cidx_ff;
      req_stall = 1'b1;
      seg_start = 1'b0;
      rv_in     = rv_ff && rsp_stall;
      ob_in     = ob_ff;
      ok_in     = ok_ff;
      oi_in     = oi_ff;
      oe_in     = oe_ff;
      ol_in     = ol_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               bit_in    = req_data_bit;
               seg_start = 1'b1;
               state_in  = ST_SEG;
            end
         end
         ST_SEG: begin
            if (seg_done) begin
               cur_in   = '0;
               bits_in  = '0;
               crc_in   = '0;
               state_in = (seg.filler_count != 6'd0) ? ST_FILL : ST_DATA;
            end
         end
         ST_FILL: begin
            if (out_free) begin
               rv_in   = 1'b1;
               ob_in   = 1'b0;
               ok_in   = KIND_FILL;
               oi_in   = cur_ff;
               oe_in   = 1'b0;
               ol_in   = 1'b0;
               crc_in  = crc_shift(crc_ff, 1'b0, poly_ff);
               bits_in = bits_next;
               if (bits_next == 13'(seg.filler_count)) state_in = ST_DATA;
            end
         end
         ST_WAIT: begin
            req_stall = 1'b0;
            if (req_valid) begin
               bit_in   = req_data_bit;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               rv_in  = 1'b1;
               ob_in  = bit_ff;
               ok_in  = KIND_DATA;
               oi_in  = cur_ff;
               oe_in  = last && !multi;
               ol_in  = !(last && multi);
               crc_in = crc_next;
               if (last && multi) begin
                  cidx_in  = '0;
                  state_in = ST_CRC;
               end else if (last) begin
                  cur_in   = cur_next[4:0];
                  bits_in  = '0;
                  crc_in   = '0;
                  state_in = (cur_next >= 6'(seg.num_blocks)) ? ST_IDLE : ST_WAIT;
               end else begin
                  bits_in  = bits_next;
                  state_in = ST_WAIT;
               end
            end
         end
         ST_CRC: begin
            // shift out parity MSB first
            if (out_free) begin
               rv_in   = 1'b1;
               ob_in   = crc_ff[CrcWidth-1];
               ok_in   = KIND_CRC;
               oi_in   = cur_ff;
               oe_in   = int'(cidx_ff) == CrcWidth - 1;
               ol_in   = int'(cidx_ff) == CrcWidth - 1;
               crc_in  = {crc_ff[CrcWidth-2:0], 1'b0};
               cidx_in = cidx_ff + 5'd1;
               if (int'(cidx_ff) == CrcWidth - 1) begin
                  cur_in   = cur_next[4:0];
                  bits_in  = '0;
                  crc_in   = '0;
                  state_in = (cur_next >= 6'(seg.num_blocks)) ? ST_IDLE : ST_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rv_ff;
   assign rsp_out_bit     = ob_ff;
   assign rsp_bit_kind    = ok_ff;
   assign rsp_block_index = oi_ff;
   assign rsp_block_end   = oe_ff;
   assign rsp_run_last    = ol_ff;

   `CBS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `CBS_ASSERT_NOW(a_crc_only_multi, clock, reset, state_ff == ST_CRC, multi)
   `CBS_ASSERT_NOW(a_fill_in_first, clock, reset, rv_ff && ok_ff == KIND_FILL, oi_ff == 5'd0)
   `CBS_ASSERT_NOW(a_wait_in_range, clock, reset, state_ff == ST_WAIT, cur_ff < seg.num_blocks)

endmodule
`default_nettype wire
